// ----- hdl/tdrt_pkg.sv -----
package tdrt_pkg;

   localparam int unsigned BlinkDivider  = 100;
   localparam int unsigned StartupBlinks = 3;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned BLINK_W  = 4;
   localparam int unsigned EVENT_W  = 2;
   localparam int unsigned CSR_AW   = 3;

   localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RUN   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PULSE = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LIT   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DARK  = 3'd4;

   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd1;
   localparam logic [EVENT_W-1:0] EV_REJECT = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_DEBOUNCE      = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_HOLDOFF       = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_PULSE         = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_BLINK_OK      = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_BLINK_ERR     = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_STARTUP_DELAY = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_STARTUP_BLINK = 3'd7;

   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD     = 10'd700;
   localparam logic [TIME_W-1:0]   RST_DEBOUNCE      = 16'd500;
   localparam logic [TIME_W-1:0]   RST_HOLDOFF       = 16'd8000;
   localparam logic [TIME_W-1:0]   RST_PULSE         = 16'd500;
   localparam logic [TIME_W-1:0]   RST_BLINK_OK      = 16'd250;
   localparam logic [TIME_W-1:0]   RST_BLINK_ERR     = 16'd600;
   localparam logic [TIME_W-1:0]   RST_STARTUP_DELAY = 16'd3000;
   localparam logic [TIME_W-1:0]   RST_STARTUP_BLINK = 16'd100;

   localparam logic [BLINK_W-1:0] BLINK_MAX = {BLINK_W{1'b1}};
   localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

   typedef struct packed {
      logic [SAMPLE_W-1:0] threshold;
      logic [TIME_W-1:0]   debounce_ms;
      logic [TIME_W-1:0]   holdoff_ms;
      logic [TIME_W-1:0]   pulse_ms;
      logic [TIME_W-1:0]   blink_ok_ms;
      logic [TIME_W-1:0]   blink_err_ms;
      logic [TIME_W-1:0]   startup_delay_ms;
      logic [TIME_W-1:0]   startup_blink_ms;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TIME_W-1:0]  phase_timer;
      logic [BLINK_W-1:0] blinks_left;
      logic [TIME_W-1:0]  blink_half_period;
      logic               last_reading;
      logic               debounced_level;
      logic [TIME_W-1:0]  since_change;
      logic [TIME_W-1:0]  since_command;
   } state_type;

   typedef struct packed {
      logic               relay_drive;
      logic               led_on;
      logic               accepting;
      logic [EVENT_W-1:0] event_res;
   } result_type;

   // Blink count of a command: sample divided by the divider, capped at the
   // counter limit. Each term is an independent compare against a constant.
   function automatic logic [BLINK_W-1:0] blink_count(input logic [SAMPLE_W-1:0] sample);
      logic [BLINK_W-1:0] cnt;
      cnt = '0;
      for (int k = 1; k <= int'(BLINK_MAX); k++) begin
         if (32'(sample) >= 32'(k * BlinkDivider)) begin
            cnt = cnt + 1'b1;
         end
      end
      return cnt;
   endfunction

   function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
      return (v == '0) ? TIME_W'(1) : v;
   endfunction

endpackage

// ----- hdl/threshold_debounce_relay_trigger_core.sv -----
// Threshold trigger with debounce, holdoff, relay pulse and LED blink codes.
// Each word on the req_ stream is one millisecond tick carrying a 10-bit
// sample; every accepted word yields exactly one word on the rsp_ stream with
// the relay level, LED level, whether the sample was evaluated and the event
// code of this tick.
// The csr_ port writes the eight timing and threshold registers; writes take
// effect on the next clock edge and are meant for idle periods only.
// The result of a word accepted at one edge is valid after that edge. Throughput
// is one word per cycle while the receiver takes results; the whole tick update is
// one pass of compare and counter logic into the state and result registers.
// The output register decouples the two sides: req_tready stays high while the
// result register is empty or being taken in the same cycle, so a stalled
// receiver holds one result and pauses the input after that.
// Synchronous reset restores all register defaults, starts the dark startup
// wait and empties the result register.
module threshold_debounce_relay_trigger_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [9:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [0] relay_drive, [1] led_on,
                                                      // [2] accepting, [4:3] event_res
   input  logic                          csr_we,
   input  logic [tdrt_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [tdrt_pkg::TIME_W-1:0]   csr_wdata
);
   import tdrt_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   tdrt_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .sample    (req_tdata[SAMPLE_W-1:0]),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= RST_THRESHOLD;
         cfg_ff.debounce_ms      <= RST_DEBOUNCE;
         cfg_ff.holdoff_ms       <= RST_HOLDOFF;
         cfg_ff.pulse_ms         <= RST_PULSE;
         cfg_ff.blink_ok_ms      <= RST_BLINK_OK;
         cfg_ff.blink_err_ms     <= RST_BLINK_ERR;
         cfg_ff.startup_delay_ms <= RST_STARTUP_DELAY;
         cfg_ff.startup_blink_ms <= RST_STARTUP_BLINK;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD:     cfg_ff.threshold        <= csr_wdata[SAMPLE_W-1:0];
            CSR_DEBOUNCE:      cfg_ff.debounce_ms      <= csr_wdata;
            CSR_HOLDOFF:       cfg_ff.holdoff_ms       <= csr_wdata;
            CSR_PULSE:         cfg_ff.pulse_ms         <= csr_wdata;
            CSR_BLINK_OK:      cfg_ff.blink_ok_ms      <= csr_wdata;
            CSR_BLINK_ERR:     cfg_ff.blink_err_ms     <= csr_wdata;
            CSR_STARTUP_DELAY: cfg_ff.startup_delay_ms <= csr_wdata;
            CSR_STARTUP_BLINK: cfg_ff.startup_blink_ms <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase             <= PH_WAIT;
         state_ff.phase_timer       <= '0;
         state_ff.blinks_left       <= BLINK_W'(StartupBlinks);
         state_ff.blink_half_period <= RST_STARTUP_BLINK;
         state_ff.last_reading      <= 1'b0;
         state_ff.debounced_level   <= 1'b0;
         state_ff.since_change      <= '0;
         state_ff.since_command     <= '0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.event_res, rsp_data_ff.accepting,
                        rsp_data_ff.led_on, rsp_data_ff.relay_drive};

endmodule

// ----- hdl/tdrt_step.sv -----
module tdrt_step (
   input  tdrt_pkg::state_type                  state_cur,
   input  tdrt_pkg::cfg_type                    cfg,
   input  logic [tdrt_pkg::SAMPLE_W-1:0]        sample,
   output tdrt_pkg::state_type                  state_nxt,
   output tdrt_pkg::result_type                 result
);
   import tdrt_pkg::*;

   state_type        s;
   logic             reading;
   logic [TIME_W:0]  tmr_inc;
   logic [TIME_W-1:0] pulse_len;
   logic [TIME_W-1:0] half_len;

   always_comb begin
      s         = state_cur;
      reading   = (sample > cfg.threshold);
      pulse_len = at_least_one(cfg.pulse_ms);
      result    = '{relay_drive: 1'b0, led_on: 1'b0, accepting: 1'b0, event_res: EV_NONE};

      if (s.phase == PH_WAIT && s.phase_timer >= cfg.startup_delay_ms) begin
         s.blinks_left       = BLINK_W'(StartupBlinks);
         s.blink_half_period = cfg.startup_blink_ms;
         s.phase_timer       = '0;
         s.phase             = (StartupBlinks != 0) ? PH_LIT : PH_RUN;
      end

      if (s.phase == PH_RUN) begin
         result.accepting = 1'b1;
         if (reading != s.last_reading) begin
            s.since_change = '0;
         end
         if (s.since_change > cfg.debounce_ms && reading != s.debounced_level) begin
            s.debounced_level = reading;
            if (reading) begin
               if (s.since_command > cfg.holdoff_ms) begin
                  result.event_res    = EV_ACCEPT;
                  s.since_command     = '0;
                  s.blinks_left       = blink_count(sample);
                  s.blink_half_period = cfg.blink_ok_ms;
                  s.phase_timer       = '0;
                  s.phase             = PH_PULSE;
               end else begin
                  result.event_res    = EV_REJECT;
                  s.blinks_left       = BLINK_W'(1);
                  s.blink_half_period = cfg.blink_err_ms;
                  s.phase_timer       = '0;
                  s.phase             = PH_LIT;
               end
            end
         end
         s.last_reading = reading;
      end

      // One bit wider so a timer that outran a shortened length still ends.
      tmr_inc  = {1'b0, s.phase_timer} + 1'b1;
      half_len = at_least_one(s.blink_half_period);

      case (s.phase)
         PH_WAIT: begin
            s.phase_timer = tmr_inc[TIME_W-1:0];
         end
         PH_PULSE: begin
            result.relay_drive = 1'b1;
            if (tmr_inc >= {1'b0, pulse_len}) begin
               s.phase_timer = '0;
               s.phase       = (s.blinks_left != '0) ? PH_LIT : PH_RUN;
            end else begin
               s.phase_timer = tmr_inc[TIME_W-1:0];
            end
         end
         PH_LIT: begin
            result.led_on = 1'b1;
            if (tmr_inc >= {1'b0, half_len}) begin
               s.phase_timer = '0;
               s.phase       = PH_DARK;
            end else begin
               s.phase_timer = tmr_inc[TIME_W-1:0];
            end
         end
         PH_DARK: begin
            if (tmr_inc >= {1'b0, half_len}) begin
               s.phase_timer = '0;
               if (s.blinks_left != '0) begin
                  s.blinks_left = s.blinks_left - 1'b1;
               end
               s.phase = (s.blinks_left != '0) ? PH_LIT : PH_RUN;
            end else begin
               s.phase_timer = tmr_inc[TIME_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (s.since_change != TIME_MAX) begin
         s.since_change = s.since_change + 1'b1;
      end
      if (s.since_command != TIME_MAX) begin
         s.since_command = s.since_command + 1'b1;
      end

      state_nxt = s;
   end

endmodule
